// ----- sv/dfe_pkg.sv -----
// Package with the shared command, status, sequencer state and result word types of the deadline FIFO.
`timescale 1ns / 1ps

package dfe_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_COMPLETED = 2'd0,
        ST_TIMED_OUT = 2'd1,
        ST_CANCELED  = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_FLUSH,
        S_CANCEL
    } state_t;

    // One result word as it leaves the sequencer.
    typedef struct packed {
        logic [7:0] tag;
        status_t    status;
        logic       last;
        logic       nonempty;
    } result_t;

endpackage

// ----- sv/deadline_fifo_with_expiry_top.sv -----
// Top level of the deadline FIFO: command sequencer over a circular entry store.
// Push completes in idle; pop, cancel and tick step through sequencer states, and
// the scan reads one entry a cycle from the single store read port. A result word is
// strobed for one cycle, in the cycle after the step that produced it; the receiver
// cannot stall. Reset (rst_n low, asynchronous) empties the queue and zeroes time.
`timescale 1ns / 1ps

module deadline_fifo_with_expiry_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] timeout,
    input  logic [7:0]  tag,
    output logic        strobe,
    output logic [7:0]  out_tag,
    output logic [1:0]  status,
    output logic        last,
    output logic        nonempty
);

    // Index width addresses the store; count width also holds the full depth.
    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W = TIME_BITS + 8;

    // Entries live in a circular buffer starting at head_reg. Adds of an index
    // and an offset never reach twice the depth, so one compare and subtract wraps.
    function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    dfe_pkg::state_t         state_reg,      state_next;
    logic [IDX_W-1:0]        head_reg,       head_next;
    logic [CNT_W-1:0]        count_reg,      count_next;
    logic [CNT_W-1:0]        k_reg,          k_next;
    logic [CNT_W-1:0]        keep_reg,       keep_next;
    logic [CNT_W-1:0]        left_reg,       left_next;
    logic [TIME_BITS-1:0]    time_reg,       time_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [7:0]              pend_tag_reg,   pend_tag_next;
    logic                    pend_ne_reg,    pend_ne_next;
    logic                    strobe_reg,     strobe_next;
    dfe_pkg::result_t        res_reg,        res_next;

    logic                    accept;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]       ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]       ram_rdata;
    logic [TIME_BITS-1:0]    rd_deadline;
    logic [7:0]              rd_tag;
    logic [TIME_BITS-1:0]    sat_sum;
    logic                    rd_expired;

    assign rd_deadline = ram_rdata[DATA_W-1:8];
    assign rd_tag      = ram_rdata[7:0];

    dfe_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The one time unit serves both the push deadline and the tick expiry test.
    dfe_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .cur_time (time_reg),
        .timeout  (timeout),
        .deadline (rd_deadline),
        .sat_sum  (sat_sum),
        .expired  (rd_expired)
    );

    assign busy   = (state_reg != dfe_pkg::S_IDLE);
    assign accept = start && !busy;

    // In idle the store is read at the head so that a pop finds its word ready on
    // the next cycle. During scans the read runs one entry ahead of the evaluation.
    assign ram_raddr = (state_reg == dfe_pkg::S_IDLE) ? head_reg
                                                      : add_mod(head_reg, k_reg[IDX_W-1:0]);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        keep_next       = keep_reg;
        left_next       = left_reg;
        time_next       = time_reg;
        pend_valid_next = pend_valid_reg;
        pend_tag_next   = pend_tag_reg;
        pend_ne_next    = pend_ne_reg;
        strobe_next     = 1'b0;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = add_mod(head_reg, count_reg[IDX_W-1:0]);
        ram_wdata       = {sat_sum, tag};

        unique case (state_reg)
            dfe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (dfe_pkg::cmd_t'(cmd))
                        dfe_pkg::CMD_PUSH:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                // A full queue turns the push away and stays as it is.
                                strobe_next       = 1'b1;
                                res_next.tag      = tag;
                                res_next.status   = dfe_pkg::ST_REJECTED;
                                res_next.last     = 1'b1;
                                res_next.nonempty = 1'b1;
                            end
                            else
                            begin
                                // Append at the tail with the clamped deadline.
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        dfe_pkg::CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = dfe_pkg::S_POP;
                            end
                        end
                        dfe_pkg::CMD_TICK:
                        begin
                            // Time stops at its maximum, but the scan still runs.
                            if (time_reg != {TIME_BITS{1'b1}})
                            begin
                                time_next = time_reg + 1'b1;
                            end
                            k_next          = '0;
                            keep_next       = '0;
                            left_next       = count_reg;
                            pend_valid_next = 1'b0;
                            state_next      = dfe_pkg::S_SCAN;
                        end
                        dfe_pkg::CMD_CANCEL:
                        begin
                            if (count_reg != '0)
                            begin
                                k_next     = '0;
                                state_next = dfe_pkg::S_CANCEL;
                            end
                        end
                    endcase
                end
            end

            dfe_pkg::S_POP:
            begin
                strobe_next       = 1'b1;
                res_next.tag      = rd_tag;
                res_next.status   = dfe_pkg::ST_COMPLETED;
                res_next.last     = 1'b1;
                res_next.nonempty = (count_reg != CNT_W'(1));
                head_next         = add_mod(head_reg, IDX_W'(1));
                count_next        = count_reg - 1'b1;
                state_next        = dfe_pkg::S_IDLE;
            end

            dfe_pkg::S_SCAN:
            begin
                // Entry k-1 is on the read port. An expired entry becomes the pending
                // word, and the previous pending word goes out knowing it is not last.
                // A live entry is copied down to the compaction slot.
                if (k_reg != '0)
                begin
                    if (rd_expired)
                    begin
                        left_next = left_reg - 1'b1;
                        if (pend_valid_reg)
                        begin
                            strobe_next       = 1'b1;
                            res_next.tag      = pend_tag_reg;
                            res_next.status   = dfe_pkg::ST_TIMED_OUT;
                            res_next.last     = 1'b0;
                            res_next.nonempty = pend_ne_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_tag_next   = rd_tag;
                        pend_ne_next    = (left_reg != CNT_W'(1));
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = add_mod(head_reg, keep_reg[IDX_W-1:0]);
                        ram_wdata = ram_rdata;
                        keep_next = keep_reg + 1'b1;
                    end
                end
                if (k_reg == count_reg)
                begin
                    state_next = dfe_pkg::S_FLUSH;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            dfe_pkg::S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    strobe_next       = 1'b1;
                    res_next.tag      = pend_tag_reg;
                    res_next.status   = dfe_pkg::ST_TIMED_OUT;
                    res_next.last     = 1'b1;
                    res_next.nonempty = pend_ne_reg;
                end
                pend_valid_next = 1'b0;
                count_next      = keep_reg;
                state_next      = dfe_pkg::S_IDLE;
            end

            dfe_pkg::S_CANCEL:
            begin
                if (k_reg != '0)
                begin
                    strobe_next       = 1'b1;
                    res_next.tag      = rd_tag;
                    res_next.status   = dfe_pkg::ST_CANCELED;
                    res_next.last     = (k_reg == count_reg);
                    res_next.nonempty = (k_reg != count_reg);
                end
                if (k_reg == count_reg)
                begin
                    count_next = '0;
                    state_next = dfe_pkg::S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = dfe_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dfe_pkg::S_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            keep_reg       <= '0;
            left_reg       <= '0;
            time_reg       <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            keep_reg       <= keep_next;
            left_reg       <= left_next;
            time_reg       <= time_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // Payload of the pending and outgoing words needs no reset.
    always_ff @(posedge clk)
    begin
        pend_tag_reg <= pend_tag_next;
        pend_ne_reg  <= pend_ne_next;
        res_reg      <= res_next;
    end

    assign strobe   = strobe_reg;
    assign out_tag  = res_reg.tag;
    assign status   = res_reg.status;
    assign last     = res_reg.last;
    assign nonempty = res_reg.nonempty;

`ifndef ASSERT_OFF
    // A result word only follows an accepted command or a busy sequencer step.
    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(start) || $past(busy)))
        else $error("result word with no command behind it");

    // The fill count never exceeds the store depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // Compaction never moves more entries than were scanned.
    a_keep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfe_pkg::S_SCAN) |-> (keep_reg <= k_reg && k_reg <= count_reg))
        else $error("compaction index ran ahead of the scan");

    // A tick leaves the survivors plus the expired words equal to the old count.
    a_tick_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dfe_pkg::S_FLUSH) |-> (keep_reg == left_reg))
        else $error("expired and surviving entries do not add up");
`endif

endmodule

// ----- sv/dfe_alu.sv -----
// Shared time unit: saturating deadline add and the expiry compare.
`timescale 1ns / 1ps

module dfe_alu #(
    parameter int TIME_BITS = 32
) (
    input  logic [TIME_BITS-1:0] cur_time,
    input  logic [31:0]          timeout,
    input  logic [TIME_BITS-1:0] deadline,
    output logic [TIME_BITS-1:0] sat_sum,
    output logic                 expired
);

    localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    logic [SUM_W-1:0] sum_wide;
    logic [SUM_W-1:0] max_wide;

    assign max_wide = {{(SUM_W-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};
    assign sum_wide = {{(SUM_W-TIME_BITS){1'b0}}, cur_time}
                    + {{(SUM_W-32){1'b0}}, timeout};

    // A deadline past the end of time is clamped to the maximum time.
    assign sat_sum = (sum_wide > max_wide) ? {TIME_BITS{1'b1}} : sum_wide[TIME_BITS-1:0];
    assign expired = (deadline <= cur_time);

endmodule

// ----- sv/dfe_ram.sv -----
// Entry store of deadline and tag, one write port and one registered read port.
`timescale 1ns / 1ps

module dfe_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
